>>> rtl/sst_pkg.sv
// Shared types and constants for the sorted set table.
// Holds the operation codes, the controller states and the command word
// that the controller broadcasts to every storage cell. No dependencies.
package sst_pkg;

	// Default number of storage cells.
	localparam int CAPACITY_DEF = 64;

	// Field widths fixed by the stream format.
	localparam int KEY_W      = 32;
	localparam int OP_W       = 2;
	localparam int CFG_W      = 7;
	localparam int FIELD_W    = 7;
	localparam int OUT_DATA_W = 24;

	// Reset value of the capacity register.
	localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

	// Flipping the sign bit makes unsigned order match signed order.
	localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_ENC1,
		ST_ENC2,
		ST_APPLY
	} state_t;

	// Command broadcast to all cells.
	typedef struct packed {
		logic             capture;
		logic             ins;
		logic             rem;
		logic [KEY_W-1:0] key;
	} cell_cmd_t;

endpackage

>>> rtl/sorted_set_table.sv
// Top level of the sorted set table: controller, row of storage cells and encoder.
// Depends on sst_pkg, sst_cell and sst_encoder.
//
//   channel  direction  payload (low bit first)
//   s_*      in         tuser: operation; tdata: value
//   m_*      out        tdata: found, position, count, full_res, changed
//   cfg_*    in         data: capacity_in_use
//
// After its input transfer an item passes through the states CMP, where every
// cell compares against the key, ENC1 and ENC2 for the boundary encoder, and
// APPLY, which shifts the cell row and loads the result register. The next item
// is taken in the cycle after the result is loaded, while that result may still
// wait for its transfer. The result stage holds, without touching the cells, as
// long as an earlier result is still unaccepted. Reset clears the fill count, the
// controller and the result valid flag and sets the capacity register to 64; the
// cell contents are left as they are.
module sorted_set_table
	import sst_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [KEY_W-1:0]      s_tdata,  // value
	input  logic [OP_W-1:0]       s_tuser,  // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // found, position, count, full_res, changed
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_W-1:0]      cfg_data  // capacity_in_use
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > CFG_W) ? CW : CFG_W;

	state_t                  state_q;
	state_t                  state_d;
	op_t                     op_q;
	logic [KEY_W-1:0]        key_q;
	logic [CW-1:0]           count_q;
	logic [CFG_W-1:0]        cap_q;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;

	logic [KEY_W-1:0]        entry_w [CAPACITY];
	logic                    lt_w    [CAPACITY];
	logic                    eq_w    [CAPACITY];
	logic [CAPACITY:0]       bnd_w;
	logic [CAPACITY:0]       hit_w;
	logic [CW-1:0]           pos_w;
	logic                    found_w;

	cell_cmd_t               cmd;
	logic                    in_fire;
	logic                    apply_fire;
	logic                    do_ins;
	logic                    do_rem;
	logic [EW-1:0]           cap_ext;
	logic [EW-1:0]           eff_cap;
	logic [CW-1:0]           count_new;
	logic                    changed_w;
	logic                    full_w;

	// Configuration register: writes come only while idle; the block does not check it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Effective capacity is the smaller of the register and the cell count.
	assign cap_ext = EW'(cap_q);
	assign eff_cap = (cap_ext < EW'(CAPACITY)) ? cap_ext : EW'(CAPACITY);

	// Input transfer.
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= op_t'(s_tuser);
			key_q <= s_tdata ^ SIGN_FLIP;
		end
	end

	// Next state and apply decision.
	always_comb begin
		state_d    = state_q;
		apply_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP:  state_d = ST_ENC1;
			ST_ENC1: state_d = ST_ENC2;
			ST_ENC2: state_d = ST_APPLY;
			ST_APPLY: begin
				if (!m_tvalid_q || m_tready) begin
					apply_fire = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operation outcome from the search result.
	assign do_ins = (op_q == OP_INSERT) && !found_w && (EW'(count_q) < eff_cap);
	assign do_rem = (op_q == OP_REMOVE) && found_w;

	always_comb begin
		count_new = count_q;
		changed_w = 1'b0;
		case (op_q)
			OP_INSERT: begin
				if (do_ins) begin
					count_new = count_q + CW'(1);
					changed_w = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (do_rem) begin
					count_new = count_q - CW'(1);
					changed_w = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_new = '0;
				changed_w = (count_q != '0);
			end
			default: begin
				count_new = count_q;
			end
		endcase
	end

	assign full_w = (EW'(count_new) >= eff_cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_fire) begin
			count_q <= count_new;
		end
	end

	// Command broadcast to the cell row.
	assign cmd.capture = (state_q == ST_CMP);
	assign cmd.ins     = apply_fire && do_ins;
	assign cmd.rem     = apply_fire && do_rem;
	assign cmd.key     = key_q;

	// Row of cells, each wired to its two neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic             lt_prev;
		logic [KEY_W-1:0] entry_prev;
		logic [KEY_W-1:0] entry_next;

		if (i == 0) begin : g_first
			assign lt_prev    = 1'b1;
			assign entry_prev = key_q;
		end else begin : g_inner
			assign lt_prev    = lt_w[i-1];
			assign entry_prev = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign entry_next = entry_w[i];
		end else begin : g_upper
			assign entry_next = entry_w[i+1];
		end

		sst_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.lt_prev    (lt_prev),
			.entry_prev (entry_prev),
			.entry_next (entry_next),
			.entry      (entry_w[i]),
			.lt         (lt_w[i]),
			.eq         (eq_w[i])
		);

		// The boundary sits where the less-than run ends.
		assign bnd_w[i] = lt_prev && !lt_w[i];
		assign hit_w[i] = bnd_w[i] && eq_w[i];
	end

	assign bnd_w[CAPACITY] = lt_w[CAPACITY-1];
	assign hit_w[CAPACITY] = 1'b0;

	sst_encoder #(
		.N  (CAPACITY + 1),
		.PW (CW)
	) u_encoder (
		.clk   (clk),
		.bnd   (bnd_w),
		.hit   (hit_w),
		.pos   (pos_w),
		.found (found_w)
	);

	// Result register; it frees the input side while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (apply_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			m_tdata_q <= {7'd0, changed_w, full_w, FIELD_W'(count_new),
				FIELD_W'(pos_w), found_w};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The fill count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// A result appears only out of the apply step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_APPLY))
		else $error("result without apply step");

	// An accepted insert grows the set by one.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_fire && do_ins) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the count");

	// A removal of a present value shrinks the set by one.
	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_fire && do_rem) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not shrink the count");

endmodule

>>> rtl/sst_cell.sv
// One storage cell of the sorted set table: a key register and its compare flags.
// Shifts toward its upper neighbor on insert and toward its lower neighbor on remove.
// Depends on sst_pkg.
module sst_cell
	import sst_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [CW-1:0]    count,
	input  logic             lt_prev,
	input  logic [KEY_W-1:0] entry_prev,
	input  logic [KEY_W-1:0] entry_next,
	output logic [KEY_W-1:0] entry,
	output logic             lt,
	output logic             eq
);

	logic [KEY_W-1:0] entry_q;
	logic             lt_q;
	logic             eq_q;
	logic             occ;

	// The cell holds a live value only below the fill count.
	assign occ = (count > CW'(INDEX));

	// Compare against the broadcast key, then shift on insert or remove.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lt_q <= occ && (entry_q < cmd.key);
			eq_q <= occ && (entry_q == cmd.key);
		end
		if (cmd.ins && !lt_q) begin
			entry_q <= lt_prev ? cmd.key : entry_prev;
		end
		if (cmd.rem && !lt_q) begin
			entry_q <= entry_next;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

>>> rtl/sst_encoder.sv
// Two-stage one-hot encoder for the insertion boundary of the cell row.
// Stage one encodes groups of eight cells, stage two merges the groups.
// Depends on sst_pkg only through the importing convention.
module sst_encoder
	import sst_pkg::*;
#(
	parameter int N  = 65,
	parameter int PW = 7
) (
	input  logic          clk,
	input  logic [N-1:0]  bnd,
	input  logic [N-1:0]  hit,
	output logic [PW-1:0] pos,
	output logic          found
);

	localparam int G = (N + 7) / 8;

	logic [2:0]    grp_idx_s1 [G];
	logic          grp_any_s1 [G];
	logic          grp_hit_s1 [G];
	logic [PW-1:0] pos_s2;
	logic          found_s2;
	logic [PW-1:0] pos_c;
	logic          found_c;

	// Stage one: local index and flags of each group of eight.
	always_ff @(posedge clk) begin
		for (int g = 0; g < G; g++) begin
			logic [2:0] idx;
			logic       any;
			logic       hh;
			idx = '0;
			any = 1'b0;
			hh  = 1'b0;
			for (int j = 0; j < 8; j++) begin
				if (g * 8 + j < N) begin
					if (bnd[g * 8 + j]) begin
						idx = idx | 3'(j);
						any = 1'b1;
					end
					hh = hh | hit[g * 8 + j];
				end
			end
			grp_idx_s1[g] <= idx;
			grp_any_s1[g] <= any;
			grp_hit_s1[g] <= hh;
		end
	end

	// Stage two: merge the group results; exactly one boundary bit is set.
	always_comb begin
		pos_c   = '0;
		found_c = 1'b0;
		for (int g = 0; g < G; g++) begin
			if (grp_any_s1[g]) begin
				pos_c = pos_c | PW'(g * 8) | PW'(grp_idx_s1[g]);
			end
			found_c = found_c | grp_hit_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		pos_s2   <= pos_c;
		found_s2 <= found_c;
	end

	assign pos   = pos_s2;
	assign found = found_s2;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for sorted_set_table: a directed table, then random phases at
// several capacity settings, checked against a shadow ordered set or typed directed results.
// Depends on sst_pkg and the sorted_set_table RTL.
module tb_top
	import sst_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = CAPACITY_DEF;
	localparam int PHASES = 11;
	// Capacity per random phase; the run never clears between phases, so a low
	// setting after a high one can leave the count above the capacity.
	localparam int PHASE_CAP [PHASES] = '{64, 10, 0, 1, 127, 33, 2, 65, 5, 64, 12};
	localparam int PHASE_LEN [PHASES] = '{300, 120, 60, 80, 220, 120, 80, 260, 100, 180, 100};

	// One result, packed in the same order as m_tdata.
	typedef struct packed {
		logic             changed;
		logic             full_res;
		logic [FIELD_W-1:0] count;
		logic [FIELD_W-1:0] position;
		logic             found;
	} set_result_t;

	typedef struct {
		op_t              op;
		logic [KEY_W-1:0] value;
		bit               typed;
		set_result_t      want;
	} set_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [KEY_W-1:0]      s_tdata = '0;  // value
	logic [OP_W-1:0]       s_tuser = '0;  // operation
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // found, position, count, full_res, changed
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0; // capacity_in_use

	// Shadow of the ordered set and the capacity register.
	logic signed [KEY_W-1:0] shadow_vals [STORE_DEPTH];
	int                      shadow_count = 0;
	int                      shadow_cap = int'(CAP_RESET);

	set_result_t pending_results [$];
	set_row_t    directed_rows [$];
	int          fault_count = 0;
	int          burst_left = 0;

	sorted_set_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_fault(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	// Searches the set as it stood, then applies the operation to the shadow copy.
	function automatic set_result_t apply_set_op(input op_t op, input logic [KEY_W-1:0] raw);
		logic signed [KEY_W-1:0] key;
		int                      cap;
		int                      pos;
		set_result_t             res;
		key = raw;
		cap = (shadow_cap < STORE_DEPTH) ? shadow_cap : STORE_DEPTH;
		pos = 0;
		res = '0;
		while (pos < shadow_count && shadow_vals[pos] < key)
			pos++;
		res.found = (pos < shadow_count) && (shadow_vals[pos] == key);
		case (op)
			OP_INSERT: begin
				if (!res.found && shadow_count < cap) begin
					for (int i = shadow_count; i > pos; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[pos] = key;
					shadow_count++;
					res.changed = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (res.found) begin
					for (int i = pos; i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_count--;
					res.changed = 1'b1;
				end
			end
			OP_CLEAR: begin
				res.changed = (shadow_count != 0);
				shadow_count = 0;
			end
			default: ;
		endcase
		res.position = pos[FIELD_W-1:0];
		res.count = shadow_count[FIELD_W-1:0];
		res.full_res = (shadow_count >= cap);
		return res;
	endfunction

	// Adds a directed row; the typed fields matter only when typed is set.
	task automatic add_row(input op_t op, input logic [KEY_W-1:0] value, input bit typed,
			input bit found, input int position, input int count, input bit full,
			input bit changed);
		set_row_t row;
		row.op = op;
		row.value = value;
		row.typed = typed;
		row.want = '{changed, full, count[FIELD_W-1:0], position[FIELD_W-1:0], found};
		directed_rows.push_back(row);
	endtask

	// Sends one item in bursts with random gaps; starts and ends at a falling edge.
	task automatic send_item(input op_t op, input logic [KEY_W-1:0] value, input bit typed,
			input set_result_t want);
		int          gap;
		set_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = apply_set_op(op, value);
		pending_results.push_back(typed ? want : predicted);
		burst_left--;
		@(negedge clk);
	endtask

	// Writes the capacity register once every result is in; ends at a falling edge.
	task automatic write_capacity(input int cap);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_cap = cap;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Picks a value: a held member with the given chance, else small, extreme or wide.
	function automatic logic [KEY_W-1:0] pick_value(input int member_pct);
		int sel;
		sel = $urandom_range(0, 99);
		if (shadow_count > 0 && sel < member_pct)
			return shadow_vals[$urandom_range(0, shadow_count - 1)];
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return KEY_W'($signed($urandom_range(0, 40)) - 20);
		if (sel == 4)
			return 32'h8000_0000 + $urandom_range(0, 3);
		if (sel == 5)
			return 32'h7FFF_FFFF - $urandom_range(0, 3);
		return $urandom;
	endfunction

	// Receiver: runs of ready or stall, with the share of ready cycles changing now and then.
	initial begin
		int run_left;
		int ready_pct;
		int cycles;
		bit hold_ready;
		run_left = 0;
		ready_pct = 100;
		cycles = 0;
		hold_ready = 1'b1;
		forever begin
			@(negedge clk);
			cycles++;
			if (cycles % 400 == 0)
				ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(25, 80);
			if (run_left == 0) begin
				run_left = $urandom_range(1, 12);
				hold_ready = ($urandom_range(0, 99) < ready_pct);
			end
			run_left--;
			m_tready <= hold_ready;
		end
	end

	// Checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		set_result_t got;
		set_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(set_result_t)-1:0];
			if (pending_results.size() == 0) begin
				report_fault($sformatf("result with nothing expected, tdata %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found)
					report_fault($sformatf("found %b, want %b", got.found, want.found));
				if (got.position !== want.position)
					report_fault($sformatf("position %0d, want %0d", got.position,
						want.position));
				if (got.count !== want.count)
					report_fault($sformatf("count %0d, want %0d", got.count, want.count));
				if (got.full_res !== want.full_res)
					report_fault($sformatf("full_res %b, want %b", got.full_res,
						want.full_res));
				if (got.changed !== want.changed)
					report_fault($sformatf("changed %b, want %b", got.changed, want.changed));
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		int          sel;
		op_t         op;
		logic [KEY_W-1:0] value;
		set_result_t none;
		none = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_vals[i] = '0;

		// Directed rows at the reset capacity: empty set, extremes, ordering, clear.
		add_row(OP_LOOKUP, 32'd0,          1, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 32'd5,          1, 0, 0, 0, 0, 0);
		add_row(OP_CLEAR,  32'd9,          1, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 32'h8000_0000,  1, 0, 0, 1, 0, 1);
		add_row(OP_INSERT, 32'h8000_0000,  1, 1, 0, 1, 0, 0);
		add_row(OP_INSERT, 32'h7FFF_FFFF,  1, 0, 1, 2, 0, 1);
		add_row(OP_INSERT, 32'h0000_0000,  0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 32'hFFFF_FFFF,  0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 32'h0000_0001,  0, 0, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 32'h7FFF_FFFF,  0, 0, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 32'h0000_0002,  0, 0, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 32'h8000_0000,  0, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 32'h0000_0000,  0, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 32'h0000_0000,  0, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 32'h7FFF_FFFF,  0, 0, 0, 0, 0, 0);
		add_row(OP_REMOVE, 32'h8000_0000,  0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 32'h5555_5555,  0, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 32'hAAAA_AAAA,  0, 0, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 32'hFFFF_FFFE,  0, 0, 0, 0, 0, 0);
		add_row(OP_CLEAR,  32'h5555_5555,  0, 0, 0, 0, 0, 0);
		add_row(OP_LOOKUP, 32'h5555_5555,  1, 0, 0, 0, 0, 0);
		add_row(OP_INSERT, 32'd7,          0, 0, 0, 0, 0, 0);

		// Reset is released at a falling edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].want);

		// Random phases: mostly inserts and hits so the set fills, rare clears.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_capacity(PHASE_CAP[ph]);
			for (int n = 0; n < PHASE_LEN[ph]; n++) begin
				sel = $urandom_range(0, 399);
				if (sel == 0) begin
					op = OP_CLEAR;
					value = $urandom;
				end else if (sel < 200) begin
					op = OP_INSERT;
					value = pick_value(15);
				end else if (sel < 300) begin
					op = OP_REMOVE;
					value = pick_value(70);
				end else begin
					op = OP_LOOKUP;
					value = pick_value(50);
				end
				send_item(op, value, 1'b0, none);
			end
		end

		// Drain: wait for every result, then keep watching for strays.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sst_encoder.sv
rtl/sorted_set_table.sv
tb/sv/tb_top.sv
